[rtl/core/ptz_command_packet_decoder_macros.svh]
// Assertion macros shared by the PTZ command packet decoder.
`ifndef PTZ_COMMAND_PACKET_DECODER_MACROS_SVH
`define PTZ_COMMAND_PACKET_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
`define PTZD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptzd assertion failed");
`define PTZD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptzd assertion failed");
`else
`define PTZD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTZD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/ptzd_pkg.sv]
// Package with the types, command codes and constants of the PTZ command packet decoder.
package ptzd_pkg;

  localparam int MAX_BYTES_DEF = 13;
  localparam int CNT_W         = 4;
  localparam int DATA_BYTES    = 10;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_SAT  = 4'hF;
  localparam logic [CNT_W-1:0] IDX_MEM  = 4'd4;
  localparam logic [CNT_W-1:0] IDX_HOME = 4'd2;
  localparam logic [CNT_W-1:0] IDX_JOG  = 4'd6;
  localparam logic [CNT_W-1:0] IDX_POS  = 4'd12;

  localparam logic [7:0] HDR_CMD    = 8'h01;
  localparam logic [7:0] HDR_PT     = 8'h06;
  localparam logic [7:0] HDR_CAM    = 8'h04;
  localparam logic [7:0] HDR_MEMORY = 8'h3F;
  localparam logic [7:0] SUB_JOG    = 8'h01;
  localparam logic [7:0] SUB_ABS    = 8'h02;
  localparam logic [7:0] SUB_REL    = 8'h03;
  localparam logic [7:0] SUB_HOME   = 8'h04;
  localparam logic [7:0] SUB_RESET  = 8'h05;
  localparam logic [7:0] SUB_MSET   = 8'h01;
  localparam logic [7:0] SUB_RECALL = 8'h02;

  localparam logic [15:0] DIR_UPLEFT    = 16'h0101;
  localparam logic [15:0] DIR_DOWNLEFT  = 16'h0102;
  localparam logic [15:0] DIR_LEFT      = 16'h0103;
  localparam logic [15:0] DIR_UPRIGHT   = 16'h0201;
  localparam logic [15:0] DIR_DOWNRIGHT = 16'h0202;
  localparam logic [15:0] DIR_RIGHT     = 16'h0203;
  localparam logic [15:0] DIR_UP        = 16'h0301;
  localparam logic [15:0] DIR_DOWN      = 16'h0302;
  localparam logic [15:0] DIR_STOP      = 16'h0303;

  localparam logic [3:0] CMD_UPLEFT    = 4'd0;
  localparam logic [3:0] CMD_DOWNLEFT  = 4'd1;
  localparam logic [3:0] CMD_LEFT      = 4'd2;
  localparam logic [3:0] CMD_UPRIGHT   = 4'd3;
  localparam logic [3:0] CMD_DOWNRIGHT = 4'd4;
  localparam logic [3:0] CMD_RIGHT     = 4'd5;
  localparam logic [3:0] CMD_UP        = 4'd6;
  localparam logic [3:0] CMD_DOWN      = 4'd7;
  localparam logic [3:0] CMD_STOP      = 4'd8;
  localparam logic [3:0] CMD_ABS       = 4'd9;
  localparam logic [3:0] CMD_REL       = 4'd10;
  localparam logic [3:0] CMD_HOME      = 4'd11;
  localparam logic [3:0] CMD_RESET     = 4'd12;
  localparam logic [3:0] CMD_MSET      = 4'd13;
  localparam logic [3:0] CMD_RECALL    = 4'd14;

  typedef struct packed {
    logic                       ok;
    logic [3:0]                 code;
    logic [DATA_BYTES-1:0][7:0] data;
  } cmd_entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

[rtl/core/ptz_command_packet_decoder.sv]
// Top level of the PTZ command packet decoder.
// The input channel takes one packet byte per beat, address and terminator
// already removed; in_last_byte marks the final byte of a packet.
// Every last-byte beat yields exactly one result beat on the output channel;
// other beats yield none. A result with out_ok low carries all-zero fields.
// Throughput is one input beat per cycle while the queue is not full: bytes are
// stored in a register file written at the byte count, and the packet is
// classified in the same cycle as its last byte.
// From the acceptance of the last byte, the result beat passes through the
// two-entry command queue and then the output register.
// When the receiver stalls, the output register holds its beat and the queue
// absorbs up to two more commands; in_ready falls only when the queue is full.
// Reset clears the byte count, the queue and the output valid flag; stored
// bytes are not cleared and need no clearing pass.
module ptz_command_packet_decoder import ptzd_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [3:0]  out_command_code,
  output logic [7:0]  out_pan_rate,
  output logic [7:0]  out_tilt_rate,
  output logic [15:0] out_pan_target,
  output logic [15:0] out_tilt_target,
  output logic [7:0]  out_preset_slot
);

`include "ptz_command_packet_decoder_macros.svh"

  cmd_entry_t push_entry;
  cmd_entry_t head;
  q_status_t  q_status;
  logic       push;
  logic       pop;

  ptzd_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_packet_byte(in_packet_byte),
    .in_last_byte  (in_last_byte),
    .q_status      (q_status),
    .push          (push),
    .entry         (push_entry)
  );

  ptzd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  ptzd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_command_code(out_command_code),
    .out_pan_rate    (out_pan_rate),
    .out_tilt_rate   (out_tilt_rate),
    .out_pan_target  (out_pan_target),
    .out_tilt_target (out_tilt_target),
    .out_preset_slot (out_preset_slot)
  );

  `PTZD_ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_valid && !out_ok, out_command_code == CMD_UPLEFT && out_pan_rate == '0 && out_tilt_rate == '0 && out_preset_slot == '0)
  `PTZD_ASSERT_IMPL(a_pos_only_moves, clk, rst_n, out_valid && out_command_code != CMD_ABS && out_command_code != CMD_REL, out_pan_target == '0 && out_tilt_target == '0)
  `PTZD_ASSERT_IMPL(a_code_range, clk, rst_n, out_valid, out_command_code <= CMD_RECALL)
  `PTZD_ASSERT_NEXT(a_push_reaches_queue, clk, rst_n, push, q_status.not_empty)

endmodule

[rtl/core/ptzd_front.sv]
// Front end: collects packet bytes and classifies the packet on its last beat.
module ptzd_front import ptzd_pkg::*; #(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_packet_byte,
  input  logic       in_last_byte,
  input  q_status_t  q_status,
  output logic       push,
  output cmd_entry_t entry
);

  localparam int IDX_W = $clog2(MAX_BYTES);
  localparam logic [CNT_W:0] MAXB = (CNT_W + 1)'(MAX_BYTES);

  logic [7:0]       store_r [MAX_BYTES];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [7:0]       mb [IDX_POS + 1];
  logic             accept;
  logic             jog_hit;
  logic [3:0]       jog_code;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_last_byte;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_last_byte) begin
        cnt_nxt = '0;
      end else if (cnt_r != CNT_SAT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ({1'b0, cnt_r} < MAXB)) begin
      store_r[cnt_r[IDX_W-1:0]] <= in_packet_byte;
    end
  end

  // The current beat is merged in so the last byte is seen before it is stored.
  always_comb begin
    for (int i = 0; i <= int'(IDX_POS); i++) begin
      mb[i] = (cnt_r == CNT_W'(i)) ? in_packet_byte : store_r[i];
    end
  end

  always_comb begin
    jog_hit  = 1'b1;
    jog_code = CMD_UPLEFT;
    unique case ({mb[5], mb[6]})
      DIR_UPLEFT:    jog_code = CMD_UPLEFT;
      DIR_DOWNLEFT:  jog_code = CMD_DOWNLEFT;
      DIR_LEFT:      jog_code = CMD_LEFT;
      DIR_UPRIGHT:   jog_code = CMD_UPRIGHT;
      DIR_DOWNRIGHT: jog_code = CMD_DOWNRIGHT;
      DIR_RIGHT:     jog_code = CMD_RIGHT;
      DIR_UP:        jog_code = CMD_UP;
      DIR_DOWN:      jog_code = CMD_DOWN;
      DIR_STOP:      jog_code = CMD_STOP;
      default:       jog_hit  = 1'b0;
    endcase
  end

  always_comb begin
    entry.ok   = 1'b0;
    entry.code = CMD_UPLEFT;
    for (int i = 0; i < DATA_BYTES; i++) begin
      entry.data[i] = mb[i + 3];
    end
    priority if (cnt_r == IDX_JOG && mb[0] == HDR_CMD && mb[1] == HDR_PT &&
                 mb[2] == SUB_JOG) begin
      entry.ok   = jog_hit;
      entry.code = jog_hit ? jog_code : CMD_UPLEFT;
    end else if (cnt_r == IDX_POS && mb[0] == HDR_CMD && mb[1] == HDR_PT &&
                 (mb[2] == SUB_ABS || mb[2] == SUB_REL)) begin
      entry.ok   = 1'b1;
      entry.code = (mb[2] == SUB_ABS) ? CMD_ABS : CMD_REL;
    end else if (cnt_r == IDX_HOME && mb[0] == HDR_CMD && mb[1] == HDR_PT &&
                 (mb[2] == SUB_HOME || mb[2] == SUB_RESET)) begin
      entry.ok   = 1'b1;
      entry.code = (mb[2] == SUB_HOME) ? CMD_HOME : CMD_RESET;
    end else if (cnt_r == IDX_MEM && mb[0] == HDR_CMD && mb[1] == HDR_CAM &&
                 mb[2] == HDR_MEMORY && (mb[3] == SUB_MSET || mb[3] == SUB_RECALL)) begin
      entry.ok   = 1'b1;
      entry.code = (mb[3] == SUB_MSET) ? CMD_MSET : CMD_RECALL;
    end else begin
      entry.ok   = 1'b0;
    end
  end

endmodule

[rtl/core/ptzd_queue.sv]
// Short queue of classified commands between the front and back ends.
module ptzd_queue import ptzd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_entry_t push_entry,
  input  logic       pop,
  output cmd_entry_t head,
  output q_status_t  status
);

  cmd_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push;
  logic              do_pop;

  assign status.not_empty = (cnt_r != '0);
  assign status.full      = (cnt_r == QCNT_W'(QDEPTH));
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign head             = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/core/ptzd_back.sv]
// Back end: formats a classified command into the registered result beat.
module ptzd_back import ptzd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_entry_t  head,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [3:0]  out_command_code,
  output logic [7:0]  out_pan_rate,
  output logic [7:0]  out_tilt_rate,
  output logic [15:0] out_pan_target,
  output logic [15:0] out_tilt_target,
  output logic [7:0]  out_preset_slot
);

  logic        valid_r;
  logic        ok_r;
  logic [3:0]  code_r;
  logic [7:0]  pan_spd_r;
  logic [7:0]  tilt_spd_r;
  logic [15:0] pan_tgt_r;
  logic [15:0] tilt_tgt_r;
  logic [7:0]  slot_r;
  logic [7:0]  pan_spd_nxt;
  logic [7:0]  tilt_spd_nxt;
  logic [15:0] pan_tgt_nxt;
  logic [15:0] tilt_tgt_nxt;
  logic [7:0]  slot_nxt;

  assign pop = q_status.not_empty && (!valid_r || out_ready);

  always_comb begin
    pan_spd_nxt  = '0;
    tilt_spd_nxt = '0;
    pan_tgt_nxt  = '0;
    tilt_tgt_nxt = '0;
    slot_nxt     = '0;
    if (head.ok) begin
      unique case (head.code)
        CMD_UPLEFT, CMD_DOWNLEFT, CMD_LEFT, CMD_UPRIGHT, CMD_DOWNRIGHT,
        CMD_RIGHT, CMD_UP, CMD_DOWN, CMD_STOP: begin
          pan_spd_nxt  = head.data[0];
          tilt_spd_nxt = head.data[1];
        end
        CMD_ABS, CMD_REL: begin
          pan_spd_nxt  = head.data[0];
          tilt_spd_nxt = head.data[1];
          pan_tgt_nxt  = {head.data[2][3:0], head.data[3][3:0],
                          head.data[4][3:0], head.data[5][3:0]};
          tilt_tgt_nxt = {head.data[6][3:0], head.data[7][3:0],
                          head.data[8][3:0], head.data[9][3:0]};
        end
        CMD_MSET, CMD_RECALL: begin
          slot_nxt = head.data[1];
        end
        default: begin
          slot_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ok_r       <= head.ok;
      code_r     <= head.ok ? head.code : CMD_UPLEFT;
      pan_spd_r  <= pan_spd_nxt;
      tilt_spd_r <= tilt_spd_nxt;
      pan_tgt_r  <= pan_tgt_nxt;
      tilt_tgt_r <= tilt_tgt_nxt;
      slot_r     <= slot_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_ok           = ok_r;
  assign out_command_code = code_r;
  assign out_pan_rate     = pan_spd_r;
  assign out_tilt_rate    = tilt_spd_r;
  assign out_pan_target   = pan_tgt_r;
  assign out_tilt_target  = tilt_tgt_r;
  assign out_preset_slot  = slot_r;

endmodule
